// ===== rtl/mwsm_pkg.sv =====
// Shared types and constants of the mecanum wheel speed mixer.
`default_nettype none

package mwsm_pkg;

  localparam int unsigned NumWheels   = 4;
  localparam int unsigned SpeedW      = 16;
  localparam int unsigned LimitW      = 15;
  // Wheel sums span three 16-bit terms, so they need 18 bits signed.
  localparam int unsigned SumW        = 18;
  localparam int unsigned MagW        = 17;
  localparam int unsigned NumW        = MagW + LimitW;
  // The scaled value never exceeds the limit, so the quotient has LimitW bits.
  localparam int unsigned DivSteps    = LimitW;

  localparam logic [LimitW-1:0] MaxSpeedReset = 15'd8000;

  typedef struct packed {
    logic signed [SpeedW-1:0] forward_speed;
    logic signed [SpeedW-1:0] side_speed;
    logic signed [SpeedW-1:0] turn_speed;
  } mwsm_in_t;

  typedef struct packed {
    logic signed [SpeedW-1:0] wheel_front_speed_a;
    logic signed [SpeedW-1:0] wheel_front_speed_b;
    logic signed [SpeedW-1:0] wheel_rear_speed_a;
    logic signed [SpeedW-1:0] wheel_rear_speed_b;
    logic                     was_scaled;
  } mwsm_out_t;

  // One classified command: wheel magnitudes and signs.
  typedef struct packed {
    logic [NumWheels-1:0]           neg;
    logic [NumWheels-1:0][MagW-1:0] mag;
  } mwsm_entry_t;

  // After the largest magnitude has been found.
  typedef struct packed {
    logic [NumWheels-1:0]           neg;
    logic [NumWheels-1:0][MagW-1:0] mag;
    logic [MagW-1:0]                largest;
    logic                           scale;
  } mwsm_cls_t;

  // One slot of the divider pipeline. rem holds the partial remainder, nq the
  // numerator bits still to be consumed and, from the bottom, quotient bits.
  typedef struct packed {
    logic [NumWheels-1:0]             neg;
    logic [NumWheels-1:0][MagW-1:0]   mag;
    logic                             scale;
    logic [MagW-1:0]                  divisor;
    logic [NumWheels-1:0][MagW-1:0]   rem;
    logic [NumWheels-1:0][LimitW-1:0] nq;
  } mwsm_div_t;

endpackage

`default_nettype wire

// ===== rtl/mwsm_front.sv =====
// Front part: mixes a command into four wheel sums and splits them into sign and magnitude.
`default_nettype none

module mwsm_front
  import mwsm_pkg::*;
(
  input  mwsm_in_t    cmd_i,
  output mwsm_entry_t entry_o
);

  logic signed [SumW-1:0] f_ext, s_ext, t_ext;
  logic signed [SumW-1:0] sum [NumWheels];
  logic        [SumW-1:0] neg_sum;

  assign f_ext = SumW'(cmd_i.forward_speed);
  assign s_ext = SumW'(cmd_i.side_speed);
  assign t_ext = SumW'(cmd_i.turn_speed);

  always_comb begin
    sum[0] = f_ext + s_ext + t_ext;
    sum[1] = f_ext - s_ext + t_ext;
    sum[2] = f_ext - s_ext - t_ext;
    sum[3] = f_ext + s_ext - t_ext;
  end

  always_comb begin
    entry_o = '0;
    neg_sum = '0;
    for (int i = 0; i < NumWheels; i++) begin
      neg_sum          = -sum[i];
      entry_o.neg[i]   = sum[i][SumW-1];
      entry_o.mag[i]   = sum[i][SumW-1] ? neg_sum[MagW-1:0] : sum[i][MagW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mwsm_queue.sv =====
// Short queue of classified commands between the front and back parts.
`default_nettype none

module mwsm_queue
  import mwsm_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  mwsm_entry_t data_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output mwsm_entry_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mwsm_entry_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mwsm_div_step.sv =====
// One registered restoring-division step, applied to all four wheel lanes.
`default_nettype none

module mwsm_div_step
  import mwsm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  mwsm_div_t stage_i,
  output logic      valid_o,
  output mwsm_div_t stage_o
);

  logic      valid_q;
  mwsm_div_t stage_q, stage_d;
  logic [MagW:0] cand;
  logic [MagW:0] diff;

  always_comb begin
    stage_d = stage_i;
    cand    = '0;
    diff    = '0;
    for (int i = 0; i < NumWheels; i++) begin
      cand = {stage_i.rem[i], stage_i.nq[i][LimitW-1]};
      diff = cand - {1'b0, stage_i.divisor};
      // No borrow means the shifted remainder reached the divisor.
      stage_d.rem[i] = diff[MagW] ? cand[MagW-1:0] : diff[MagW-1:0];
      stage_d.nq[i]  = {stage_i.nq[i][LimitW-2:0], !diff[MagW]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

// ===== rtl/mwsm_back.sv =====
// Back part: finds the largest wheel, scales through a pipelined divider, holds the result.
`default_nettype none

module mwsm_back
  import mwsm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [LimitW-1:0] limit_i,
  input  logic              head_valid_i,
  input  mwsm_entry_t       head_i,
  output logic              head_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output mwsm_out_t         out_o
);

  logic adv;

  // Classification stage.
  logic      cls_valid_q;
  mwsm_cls_t cls_q, cls_d;
  logic [MagW-1:0] max01, max23;

  // Multiply stage and divider chain.
  logic      div_valid [DivSteps+1];
  mwsm_div_t div_stage [DivSteps+1];
  mwsm_div_t mul_d;
  logic [NumW-1:0] prod;

  // Output register.
  logic      out_valid_q;
  mwsm_out_t out_q, out_d;
  logic [MagW-1:0]   val;
  logic [MagW-1:0]   sval;
  logic [SpeedW-1:0] wheel [NumWheels];

  // The whole pipeline moves whenever the output register is free or being read.
  assign adv        = !out_valid_q || pop_i;
  assign head_pop_o = adv && head_valid_i;

  always_comb begin
    max01         = (head_i.mag[0] > head_i.mag[1]) ? head_i.mag[0] : head_i.mag[1];
    max23         = (head_i.mag[2] > head_i.mag[3]) ? head_i.mag[2] : head_i.mag[3];
    cls_d.neg     = head_i.neg;
    cls_d.mag     = head_i.mag;
    cls_d.largest = (max01 > max23) ? max01 : max23;
    cls_d.scale   = (cls_d.largest > MagW'(limit_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_valid_q <= 1'b0;
    end else if (adv) begin
      cls_valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cls_q <= cls_d;
    end
  end

  always_comb begin
    mul_d         = '0;
    prod          = '0;
    mul_d.neg     = cls_q.neg;
    mul_d.mag     = cls_q.mag;
    mul_d.scale   = cls_q.scale;
    mul_d.divisor = cls_q.largest;
    for (int i = 0; i < NumWheels; i++) begin
      prod          = NumW'(cls_q.mag[i]) * NumW'(limit_i);
      mul_d.rem[i]  = prod[NumW-1:LimitW];
      mul_d.nq[i]   = prod[LimitW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_valid[0] <= 1'b0;
    end else if (adv) begin
      div_valid[0] <= cls_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_stage[0] <= mul_d;
    end
  end

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    mwsm_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (div_valid[g]),
      .stage_i (div_stage[g]),
      .valid_o (div_valid[g+1]),
      .stage_o (div_stage[g+1])
    );
  end

  always_comb begin
    out_d = '0;
    val   = '0;
    sval  = '0;
    for (int i = 0; i < NumWheels; i++) begin
      val = div_stage[DivSteps].scale ? MagW'(div_stage[DivSteps].nq[i])
                                      : div_stage[DivSteps].mag[i];
      sval     = div_stage[DivSteps].neg[i] ? -val : val;
      wheel[i] = sval[SpeedW-1:0];
    end
    out_d.wheel_front_speed_a = $signed(wheel[0]);
    out_d.wheel_front_speed_b = $signed(wheel[1]);
    out_d.wheel_rear_speed_a  = $signed(wheel[2]);
    out_d.wheel_rear_speed_b  = $signed(wheel[3]);
    out_d.was_scaled          = div_stage[DivSteps].scale;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= div_valid[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign empty_o = !out_valid_q;
  assign out_o   = out_q;

endmodule

`default_nettype wire

// ===== rtl/mecanum_wheel_speed_mixer.sv =====
// Mecanum chassis inverse kinematics with proportional wheel speed limiting.
//
// Commands enter through a queue-style port: drive in_i and raise push; the
// command is taken at a clock edge where push is high and full is low. Results
// leave the same way: while empty is low, out_o shows the oldest result, and it
// is taken at an edge where pop is high. The limit register is written through
// the cfg channel (cfg_ready_o is always high) and must only change while no
// command is in flight.
// A command taken at an edge passes in order through the command queue, the
// largest-wheel search register, the register after the four multipliers, the
// one-bit-per-stage divider and the output register before its result shows.
// One command per cycle is sustained as long as results are popped.
// When the receiver stalls, the output register holds its result and the whole
// back pipeline freezes, while the front queue keeps taking commands until it
// holds QueueDepth of them and raises full.
// Reset empties the queue and the pipeline and sets the limit to 8000.

`default_nettype none

module mecanum_wheel_speed_mixer
  import mwsm_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [LimitW-1:0] cfg_data_i,
  input  logic              push,
  output logic              full,
  input  mwsm_in_t          in_i,
  output logic              empty,
  input  logic              pop,
  output mwsm_out_t         out_o
);

  logic [LimitW-1:0] max_wheel_speed_q;
  mwsm_entry_t       front_entry;
  mwsm_entry_t       head;
  logic              head_valid;
  logic              head_pop;

  // The limit register can always take a write.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_wheel_speed_q <= MaxSpeedReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_wheel_speed_q <= cfg_data_i;
    end
  end

  // Mixing and sign/magnitude split happen on the way into the queue.
  mwsm_front u_front (
    .cmd_i   (in_i),
    .entry_o (front_entry)
  );

  mwsm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_entry),
    .full_o  (full),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .data_o  (head)
  );

  // Scaling by limit/largest, then the output register.
  mwsm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .limit_i      (max_wheel_speed_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the mecanum wheel speed mixer with speed limiting.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mwsm_pkg::*;

  // The pipeline latency of a command through the block, also used as the base of
  // the settle time before a limit write and after the last result.
  localparam int LatencyCycles = 18;

  // Wheel targets predicted from accepted commands, checked in arrival order.
  class wheel_target_board;
    logic [LimitW-1:0] speed_limit;
    mwsm_out_t         targets_due[$];
    int                mismatches;
    int                targets_checked;
    int                targets_scaled;

    function new();
      speed_limit     = MaxSpeedReset;
      mismatches      = 0;
      targets_checked = 0;
      targets_scaled  = 0;
    endfunction

    // Mix the chassis command into four wheel sums and scale all of them by
    // limit/largest when the largest magnitude is above the limit.
    function mwsm_out_t mix_and_limit(mwsm_in_t cmd);
      longint    fwd, side, turn, largest, lim;
      longint    sums[NumWheels];
      longint    scaled[NumWheels];
      bit        over;
      mwsm_out_t res;
      fwd  = longint'(cmd.forward_speed);
      side = longint'(cmd.side_speed);
      turn = longint'(cmd.turn_speed);
      lim  = longint'(speed_limit);
      sums[0] = fwd + side + turn;
      sums[1] = fwd - side + turn;
      sums[2] = fwd - side - turn;
      sums[3] = fwd + side - turn;
      largest = 0;
      foreach (sums[i]) begin
        if ((sums[i] < 0 ? -sums[i] : sums[i]) > largest) begin
          largest = sums[i] < 0 ? -sums[i] : sums[i];
        end
      end
      over = largest > lim;
      foreach (sums[i]) begin
        // Signed integer division truncates toward zero.
        scaled[i] = over ? (sums[i] * lim) / largest : sums[i];
      end
      res.wheel_front_speed_a = scaled[0][SpeedW-1:0];
      res.wheel_front_speed_b = scaled[1][SpeedW-1:0];
      res.wheel_rear_speed_a  = scaled[2][SpeedW-1:0];
      res.wheel_rear_speed_b  = scaled[3][SpeedW-1:0];
      res.was_scaled          = over;
      return res;
    endfunction

    function void note_command(mwsm_in_t cmd);
      targets_due.push_back(mix_and_limit(cmd));
    endfunction

    function void check_targets(mwsm_out_t got);
      mwsm_out_t exp;
      if (targets_due.size() == 0) begin
        $error("Result arrived with no command outstanding");
        mismatches++;
        return;
      end
      exp = targets_due.pop_front();
      targets_checked++;
      if (exp.was_scaled) targets_scaled++;
      if (got.wheel_front_speed_a !== exp.wheel_front_speed_a) begin
        $error("wheel_front_speed_a: expected %0d, got %0d",
               exp.wheel_front_speed_a, got.wheel_front_speed_a);
        mismatches++;
      end
      if (got.wheel_front_speed_b !== exp.wheel_front_speed_b) begin
        $error("wheel_front_speed_b: expected %0d, got %0d",
               exp.wheel_front_speed_b, got.wheel_front_speed_b);
        mismatches++;
      end
      if (got.wheel_rear_speed_a !== exp.wheel_rear_speed_a) begin
        $error("wheel_rear_speed_a: expected %0d, got %0d",
               exp.wheel_rear_speed_a, got.wheel_rear_speed_a);
        mismatches++;
      end
      if (got.wheel_rear_speed_b !== exp.wheel_rear_speed_b) begin
        $error("wheel_rear_speed_b: expected %0d, got %0d",
               exp.wheel_rear_speed_b, got.wheel_rear_speed_b);
        mismatches++;
      end
      if (got.was_scaled !== exp.was_scaled) begin
        $error("was_scaled: expected %0d, got %0d", exp.was_scaled, got.was_scaled);
        mismatches++;
      end
    endfunction
  endclass

  // Every input starts at a known value; reset is held low from time zero.
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [LimitW-1:0] cfg_data_i  = '0;
  logic              push        = 1'b0;
  logic              full;
  mwsm_in_t          in_i        = '0;
  logic              empty;
  logic              pop         = 1'b0;
  mwsm_out_t         out_o;

  wheel_target_board board;
  int                limits_used;
  // When set, the command side sends back to back with no gaps.
  bit                send_steady;

  mecanum_wheel_speed_mixer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .in_i        (in_i),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Stimulus is driven with nonblocking assignments at the rising edge, and the
  // block's outputs are read right after the edge, before its own updates land,
  // so every handshake decision sees the values that the edge itself saw.

  // Issue one command request. It is taken at the first edge where full is low.
  // Push stays high on return, so a back-to-back request keeps it high without
  // lowering it in between.
  task automatic send_command(mwsm_in_t cmd);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= cmd;
    do @(posedge clk_i); while (full);
    board.note_command(cmd);
  endtask

  function automatic mwsm_in_t make_command(int fwd, int side, int turn);
    mwsm_in_t cmd;
    cmd.forward_speed = 16'(fwd);
    cmd.side_speed    = 16'(side);
    cmd.turn_speed    = 16'(turn);
    return cmd;
  endfunction

  // Random commands: full-range values, the most frequent kind, which exercise
  // every bit and nearly always trip the limit, plus moderate and tiny values that
  // may pass through unscaled, the corners of the 16-bit range and single-axis ones.
  function automatic mwsm_in_t random_command();
    mwsm_in_t          cmd;
    int unsigned       kind;
    logic [SpeedW-1:0] corners[5];
    corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
    kind = $urandom_range(0, 9);
    if (kind <= 3) begin
      cmd = make_command($urandom, $urandom, $urandom);
    end else if (kind <= 6) begin
      cmd = make_command(int'($urandom_range(0, 6000)) - 3000,
                         int'($urandom_range(0, 6000)) - 3000,
                         int'($urandom_range(0, 6000)) - 3000);
    end else if (kind == 7) begin
      cmd.forward_speed = corners[$urandom_range(0, 4)];
      cmd.side_speed    = corners[$urandom_range(0, 4)];
      cmd.turn_speed    = corners[$urandom_range(0, 4)];
    end else if (kind == 8) begin
      cmd = make_command(int'($urandom_range(0, 8)) - 4,
                         int'($urandom_range(0, 8)) - 4,
                         int'($urandom_range(0, 8)) - 4);
    end else begin
      // A single axis at a time, zero on the others.
      cmd = '0;
      case ($urandom_range(0, 2))
        0:       cmd.forward_speed = 16'($urandom);
        1:       cmd.side_speed    = 16'($urandom);
        default: cmd.turn_speed    = 16'($urandom);
      endcase
    end
    return cmd;
  endfunction

  // The limit may only change with nothing in flight: wait for every predicted
  // result, let the pipeline settle, then issue one configuration request.
  task automatic write_speed_limit(logic [LimitW-1:0] lim);
    push <= 1'b0;
    while (board.targets_due.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles + 2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= lim;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.speed_limit = lim;
    limits_used++;
  endtask

  // A run of random commands, switching between gapped and back-to-back
  // sending every few dozen requests.
  task automatic send_random_run(int count);
    int left;
    left = 0;
    repeat (count) begin
      if (left == 0) begin
        send_steady = ($urandom_range(0, 3) == 0);
        left        = $urandom_range(10, 60);
      end
      left--;
      send_command(random_command());
    end
    send_steady = 1'b0;
  endtask

  // Result side: pops with random stalls and, now and then, a stretch where
  // pop stays high. Every accepted result goes to the scoreboard. Nothing is
  // sampled until reset has been released and the outputs are known.
  initial begin : result_drain
    int stall;
    int left;
    bit steady;
    left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      if (left == 0) begin
        steady = ($urandom_range(0, 3) == 0);
        left   = $urandom_range(10, 60);
      end
      left--;
      stall = steady ? 0 : $urandom_range(0, 9);
      repeat (stall) begin
        pop <= 1'b0;
        @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      board.check_targets(out_o);
    end
  end

  // Hard stop well beyond the slowest correct run: about 2000 requests, each worth
  // at most its longest random gap, its longest stall and the pipeline latency.
  initial begin : watchdog
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : main_sequence
    logic [LimitW-1:0] random_limits[7];
    board       = new();
    limits_used = 1;
    send_steady = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset limit of 8000: zero command, saturated
    // corners, a wheel exactly at the limit (kept) and one above it (scaled).
    send_command(make_command(0, 0, 0));
    send_command(make_command(32767, 32767, 32767));
    send_command(make_command(-32768, -32768, -32768));
    send_command(make_command(32767, -32768, 32767));
    send_command(make_command(-32768, 32767, -32768));
    send_command(make_command(8000, 0, 0));
    send_command(make_command(8001, 0, 0));
    send_command(make_command(1000, -2000, 3000));
    send_command(make_command(0, 0, -8001));

    // A limit of zero forces every nonzero command to all-zero wheels, while
    // a zero command passes through unscaled.
    write_speed_limit('0);
    send_command(make_command(0, 0, 0));
    send_command(make_command(1, 0, 0));
    send_command(make_command(-1, 1, -1));
    send_command(make_command(-32768, 32767, 0));

    // The top limit: a magnitude of exactly 32767 passes, 32768 and the
    // largest sums of 98304 are scaled.
    write_speed_limit('1);
    send_command(make_command(32767, 0, 0));
    send_command(make_command(32767, 1, 0));
    send_command(make_command(-32768, 0, 0));
    send_command(make_command(32767, 32767, -32768));
    send_command(make_command(-32768, -32768, -32768));

    // A limit of one: truncation toward zero dominates.
    write_speed_limit(15'd1);
    send_command(make_command(1, 0, 0));
    send_command(make_command(0, 1, 1));
    send_command(make_command(3, -7, 2));

    // Random part across a spread of limits, extremes included.
    random_limits = '{15'($urandom), 15'd1, '1, '0, 15'($urandom_range(0, 100)),
                      15'($urandom), MaxSpeedReset};
    foreach (random_limits[i]) begin
      write_speed_limit(random_limits[i]);
      send_random_run(270);
    end

    push <= 1'b0;
    while (board.targets_due.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles + 2) @(posedge clk_i);

    $display("Checked %0d sets of wheel targets (%0d scaled) under %0d speed limits,",
             board.targets_checked, board.targets_scaled, limits_used);
    $display("with random gaps and stalls on both sides and back-to-back stretches.");
    if (board.mismatches == 0 && board.targets_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
